// ===== design/ftc_pkg.sv =====
// Package with the shared constants, types and helper functions of the flame threshold calibrator.
`timescale 1ns / 1ps
`default_nettype none

package ftc_pkg;

    // Samples averaged per block, both in work mode and during a capture.
    localparam int WINDOW_LEN = 10;
    localparam int CNT_W      = $clog2(WINDOW_LEN);

    localparam int SAMPLE_W = 12;
    localparam int SUM_W    = 16;
    localparam int TICK_W   = 10;
    localparam int PHASE_W  = 8;
    localparam int SCALE_W  = 7;
    localparam int PROD_W   = SAMPLE_W + SCALE_W;
    localparam int THR_EXT_W = 13;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Exact floor(sum / WINDOW_LEN) for a 16-bit sum by a reciprocal multiply.
    localparam int WIN_SHIFT   = SUM_W + 5;
    localparam int WIN_RECIP_W = WIN_SHIFT + 1;
    localparam logic [WIN_RECIP_W-1:0] WIN_RECIP =
        WIN_RECIP_W'(((2 ** WIN_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);

    // Exact floor(x / 100) for a 19-bit product by a reciprocal multiply.
    localparam int HUND_SHIFT   = PROD_W + 7;
    localparam int HUND_RECIP_W = 20;
    localparam logic [HUND_RECIP_W-1:0] HUND_RECIP =
        HUND_RECIP_W'(((2 ** HUND_SHIFT) + 99) / 100);

    localparam logic [SAMPLE_W-1:0] THR_MAX  = '1;
    localparam logic [TICK_W-1:0]   TICK_MAX = '1;

    // Reset values of the configuration registers.
    localparam logic [TICK_W-1:0]  HOLD_TICKS_RST    = TICK_W'(300);
    localparam logic [PHASE_W-1:0] PROG_BLINK_RST    = PHASE_W'(10);
    localparam logic [TICK_W-1:0]  STARTUP_TICKS_RST = TICK_W'(120);
    localparam logic [PHASE_W-1:0] START_BLINK_RST   = PHASE_W'(20);
    localparam logic [SCALE_W-1:0] SCALE_RST         = SCALE_W'(95);
    localparam logic [SAMPLE_W-1:0] THR_PRELOAD_RST  = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_TICKS    = 3'd0,
        CFG_PROG_BLINK    = 3'd1,
        CFG_STARTUP_TICKS = 3'd2,
        CFG_START_BLINK   = 3'd3,
        CFG_SCALE         = 3'd4,
        CFG_THR_PRELOAD   = 3'd5
    } t_cfg_idx;

    // Mode as seen on the result beat.
    localparam logic [1:0] MODE_CODE_STARTUP = 2'd0;
    localparam logic [1:0] MODE_CODE_WORK    = 2'd1;
    localparam logic [1:0] MODE_CODE_PROGRAM = 2'd2;
    localparam logic [1:0] MODE_CODE_CAPTURE = 2'd3;

    // Result beat layout.
    localparam int OUT_FLAME_BIT = 0;
    localparam int OUT_LED_BIT   = 1;
    localparam int OUT_MODE_LSB  = 2;
    localparam int OUT_THR_LSB   = 4;
    localparam int OUT_AVG_LSB   = 16;

    function automatic logic [SAMPLE_W-1:0] div_window(input logic [SUM_W-1:0] sum);
        logic [SUM_W+WIN_RECIP_W-1:0] prod;
        prod = (SUM_W+WIN_RECIP_W)'(sum) * (SUM_W+WIN_RECIP_W)'(WIN_RECIP);
        return prod[WIN_SHIFT +: SAMPLE_W];
    endfunction

    function automatic logic [THR_EXT_W-1:0] div_hundred(input logic [PROD_W-1:0] x);
        logic [PROD_W+HUND_RECIP_W-1:0] prod;
        prod = (PROD_W+HUND_RECIP_W)'(x) * (PROD_W+HUND_RECIP_W)'(HUND_RECIP);
        return prod[HUND_SHIFT +: THR_EXT_W];
    endfunction

endpackage

`default_nettype wire

// ===== design/flame_threshold_calibrator.sv =====
// Top level of the flame threshold calibrator: tick registers, mode logic and result register.
//
//  Channel  | Direction | Beat contents (lowest bit first)
//  ---------+-----------+-----------------------------------------------------------
//  s_axis   | in        | sample[11:0], button_pressed[12], zero pad to 16 bits
//  m_axis   | out       | flame, led, mode[1:0], threshold[11:0], average[11:0], pad to 32
//  i_cfg_*  | in        | write enable, register index (0..5), 12-bit write data
//
// An accepted tick passes through the input register to the mode logic, and its result
// leaves the result register the cycle after, so one tick per cycle flows in steady state
// while m_axis does not stall. The tick that completes a calibration capture holds the input
// through block average, then average times scale, then the divide by one hundred.
// Reset is synchronous; it clears all control state with no clearing pass.
// A stall on m_axis holds the result register and backs up through the input register.
`timescale 1ns / 1ps
`default_nettype none

module flame_threshold_calibrator
    import ftc_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    // sample[11:0], button_pressed[12], zeros above
    input  wire  [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    // flame_detected[0], indicator_led[1], mode_now[3:2], threshold_level[15:4],
    // block_average[27:16], zeros above
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  wire                   i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [5:0] {
        MODE_STARTUP   = 6'b000001,
        MODE_WORK      = 6'b000010,
        MODE_PROGRAM   = 6'b000100,
        MODE_CAPTURE   = 6'b001000,
        MODE_CAL_AVG   = 6'b010000,
        MODE_CAL_SCALE = 6'b100000
    } t_mode;

    // Configuration registers.
    logic [TICK_W-1:0]  r_hold_ticks;
    logic [PHASE_W-1:0] r_prog_blink;
    logic [TICK_W-1:0]  r_startup_ticks;
    logic [PHASE_W-1:0] r_start_blink;
    logic [SCALE_W-1:0] r_scale;

    // Input register.
    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_in_sample;
    logic                r_in_press;

    // Mode state.
    t_mode               r_mode, n_mode;
    logic [CNT_W-1:0]    r_win_cnt, n_win_cnt;
    logic [SUM_W-1:0]    r_win_sum, n_win_sum;
    logic [SAMPLE_W-1:0] r_avg, n_avg;
    logic [SAMPLE_W-1:0] r_thr, n_thr;
    logic [TICK_W-1:0]   r_tick, n_tick;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic                r_led, n_led;
    logic                r_flame, n_flame;
    logic [SAMPLE_W-1:0] r_cal_avg, n_cal_avg;
    logic [PROD_W-1:0]   r_cal_prod, n_cal_prod;

    // Result register.
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    logic                  out_free;
    logic                  take_tick;
    logic                  emit;
    logic [SUM_W-1:0]      sum_add;
    logic [SAMPLE_W-1:0]   sum_avg;
    logic                  win_last;
    logic [PHASE_W-1:0]    phase_step;
    logic [PHASE_W-1:0]    blink_period;
    logic [TICK_W-1:0]     tick_inc;
    logic [THR_EXT_W-1:0]  thr_scaled;
    logic [1:0]            mode_code;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign take_tick     = r_in_valid && out_free &&
                           (r_mode != MODE_CAL_AVG) && (r_mode != MODE_CAL_SCALE);
    assign s_axis_tready = !r_in_valid || take_tick;

    assign sum_add    = r_win_sum + SUM_W'(r_in_sample);
    assign sum_avg    = div_window(sum_add);
    assign win_last   = (r_win_cnt == CNT_W'(WINDOW_LEN - 1));
    assign phase_step = r_phase + PHASE_W'(1);
    assign tick_inc   = (r_tick == TICK_MAX) ? r_tick : r_tick + TICK_W'(1);
    assign thr_scaled = div_hundred(r_cal_prod);
    assign blink_period = (r_mode == MODE_STARTUP) ? r_start_blink : r_prog_blink;

    always_comb begin
        n_mode     = r_mode;
        n_win_cnt  = r_win_cnt;
        n_win_sum  = r_win_sum;
        n_avg      = r_avg;
        n_thr      = r_thr;
        n_tick     = r_tick;
        n_phase    = r_phase;
        n_led      = r_led;
        n_flame    = r_flame;
        n_cal_avg  = r_cal_avg;
        n_cal_prod = r_cal_prod;
        emit       = 1'b0;

        // Shared LED blinker for startup and program modes.
        if ((r_mode == MODE_STARTUP) || (r_mode == MODE_PROGRAM)) begin
            if (phase_step >= blink_period) begin
                n_phase = '0;
                n_led   = !r_led;
            end else begin
                n_phase = phase_step;
            end
        end

        case (r_mode)
            MODE_STARTUP: begin
                if (take_tick) begin
                    emit   = 1'b1;
                    n_tick = tick_inc;
                    if (tick_inc >= r_startup_ticks) begin
                        n_led   = 1'b1;
                        n_mode  = MODE_WORK;
                        n_tick  = '0;
                        n_phase = '0;
                    end
                end else begin
                    n_phase = r_phase;
                    n_led   = r_led;
                end
            end
            MODE_WORK: begin
                if (take_tick) begin
                    emit      = 1'b1;
                    n_win_sum = sum_add;
                    n_win_cnt = r_win_cnt + CNT_W'(1);
                    if (win_last) begin
                        n_avg     = sum_avg;
                        n_win_sum = '0;
                        n_win_cnt = '0;
                    end
                    n_flame = (n_avg >= r_thr);
                    n_tick  = r_in_press ? tick_inc : '0;
                    if (n_tick >= r_hold_ticks) begin
                        n_mode  = MODE_PROGRAM;
                        n_tick  = '0;
                        n_phase = '0;
                    end
                end
            end
            MODE_PROGRAM: begin
                if (take_tick) begin
                    emit = 1'b1;
                    if (!r_in_press) begin
                        n_mode    = MODE_CAPTURE;
                        n_win_cnt = '0;
                        n_win_sum = '0;
                    end
                end else begin
                    n_phase = r_phase;
                    n_led   = r_led;
                end
            end
            MODE_CAPTURE: begin
                if (take_tick) begin
                    n_win_sum = sum_add;
                    n_win_cnt = r_win_cnt + CNT_W'(1);
                    if (win_last) begin
                        // The result of this tick leaves once the new threshold is ready.
                        n_cal_avg = sum_avg;
                        n_win_sum = '0;
                        n_win_cnt = '0;
                        n_mode    = MODE_CAL_AVG;
                    end else begin
                        emit = 1'b1;
                    end
                end
            end
            MODE_CAL_AVG: begin
                n_cal_prod = PROD_W'(r_cal_avg) * PROD_W'(r_scale);
                n_mode     = MODE_CAL_SCALE;
            end
            MODE_CAL_SCALE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_thr   = (thr_scaled > THR_EXT_W'(THR_MAX)) ? THR_MAX
                                                                 : thr_scaled[SAMPLE_W-1:0];
                    n_led   = 1'b1;
                    n_mode  = MODE_WORK;
                    n_tick  = '0;
                    n_phase = '0;
                end
            end
            default: begin
                n_mode = MODE_STARTUP;
            end
        endcase
    end

    always_comb begin
        case (n_mode)
            MODE_STARTUP:   mode_code = MODE_CODE_STARTUP;
            MODE_WORK:      mode_code = MODE_CODE_WORK;
            MODE_PROGRAM:   mode_code = MODE_CODE_PROGRAM;
            default:        mode_code = MODE_CODE_CAPTURE;
        endcase
        n_out_data                         = '0;
        n_out_data[OUT_FLAME_BIT]          = n_flame;
        n_out_data[OUT_LED_BIT]            = n_led;
        n_out_data[OUT_MODE_LSB +: 2]      = mode_code;
        n_out_data[OUT_THR_LSB +: SAMPLE_W] = n_thr;
        n_out_data[OUT_AVG_LSB +: SAMPLE_W] = n_avg;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks    <= HOLD_TICKS_RST;
            r_prog_blink    <= PROG_BLINK_RST;
            r_startup_ticks <= STARTUP_TICKS_RST;
            r_start_blink   <= START_BLINK_RST;
            r_scale         <= SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HOLD_TICKS:    r_hold_ticks    <= i_cfg_data[TICK_W-1:0];
                CFG_PROG_BLINK:    r_prog_blink    <= i_cfg_data[PHASE_W-1:0];
                CFG_STARTUP_TICKS: r_startup_ticks <= i_cfg_data[TICK_W-1:0];
                CFG_START_BLINK:   r_start_blink   <= i_cfg_data[PHASE_W-1:0];
                CFG_SCALE:         r_scale         <= i_cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_sample <= s_axis_tdata[SAMPLE_W-1:0];
            r_in_press  <= s_axis_tdata[SAMPLE_W];
        end
    end

    // Mode state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_STARTUP;
            r_win_cnt <= '0;
            r_win_sum <= '0;
            r_avg     <= '0;
            r_thr     <= THR_PRELOAD_RST;
            r_tick    <= '0;
            r_phase   <= '0;
            r_led     <= 1'b1;
            r_flame   <= 1'b0;
        end else begin
            r_mode    <= n_mode;
            r_win_cnt <= n_win_cnt;
            r_win_sum <= n_win_sum;
            r_avg     <= n_avg;
            r_tick    <= n_tick;
            r_phase   <= n_phase;
            r_led     <= n_led;
            r_flame   <= n_flame;
            // A preload write stands for the stored setting and takes effect at once.
            if (i_cfg_we && (i_cfg_idx == CFG_THR_PRELOAD)) begin
                r_thr <= i_cfg_data[SAMPLE_W-1:0];
            end else begin
                r_thr <= n_thr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cal_avg  <= n_cal_avg;
        r_cal_prod <= n_cal_prod;
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== design/ftc_checker.sv =====
// Port-level checker for the flame threshold calibrator and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module ftc_checker
    import ftc_pkg::*;
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  s_axis_tready,
    input wire                  m_axis_tvalid,
    input wire                  m_axis_tready,
    input wire [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [1:0]          beat_mode;
    logic [SAMPLE_W-1:0] beat_avg;
    logic                beat_flame;

    assign beat_mode  = m_axis_tdata[OUT_MODE_LSB +: 2];
    assign beat_avg   = m_axis_tdata[OUT_AVG_LSB +: SAMPLE_W];
    assign beat_flame = m_axis_tdata[OUT_FLAME_BIT];

    // A result that waits is neither dropped nor changed.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed or dropped while stalled");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Reset empties the input register, so the first beat is taken at once.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready right after reset");

    // Startup comes only after reset, before any block has been averaged.
    a_startup_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (beat_mode == MODE_CODE_STARTUP) |-> !beat_flame && (beat_avg == '0))
        else $error("startup beat shows flame or a block average");

endmodule

bind flame_threshold_calibrator ftc_checker u_ftc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== bench/tb_flame_threshold_calibrator.sv =====
// Self-checking testbench for the flame threshold calibrator tick stream.
`timescale 1ns / 1ps

module tb_flame_threshold_calibrator;
    import ftc_pkg::*;

    localparam int RAND_TICKS     = 1450;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 300;
    localparam int DIR_ROWS       = 25;

    // Register indexes with no register behind them.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

    // Result beat, flame in bit 0.
    typedef struct packed {
        logic [SAMPLE_W-1:0] avg;
        logic [SAMPLE_W-1:0] thr;
        logic [1:0]          mode;
        logic                led;
        logic                flame;
    } calib_result_t;

    typedef enum logic {ROW_CFG, ROW_TICK} row_kind_e;

    typedef struct packed {
        row_kind_e            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] data;
        logic [SAMPLE_W-1:0]  smp;
        logic                 btn;
        logic [3:0]           rep;
        logic                 typed;
        calib_result_t        res;
    } stim_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    flame_threshold_calibrator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Predictor copy of the configuration and the state.
    logic [TICK_W-1:0]   cfg_hold;
    logic [PHASE_W-1:0]  cfg_prog_blink;
    logic [TICK_W-1:0]   cfg_start_ticks;
    logic [PHASE_W-1:0]  cfg_start_blink;
    logic [SCALE_W-1:0]  cfg_scale;
    logic [SAMPLE_W-1:0] cfg_preload;

    logic [1:0]          cal_mode;
    logic [3:0]          win_cnt;
    logic [SUM_W-1:0]    win_sum;
    logic [SAMPLE_W-1:0] avg_q;
    logic [SAMPLE_W-1:0] thr_q;
    logic [TICK_W-1:0]   tick_cnt;
    logic [PHASE_W-1:0]  blink_ph;
    logic                led_q;
    logic                flame_q;

    calib_result_t result_q[$];
    int            mismatch_cnt = 0;
    int            idle_cycles = 0;

    // Set by the sender alongside each beat it offers.
    logic          tick_typed;
    calib_result_t tick_typed_res;

    int ticks_sent = 0;
    int burst_left = 0;
    bit free_run = 1'b0;
    bit long_hold_req = 1'b0;

    function automatic void advance_blink(input logic [PHASE_W-1:0] period);
        blink_ph = blink_ph + 8'd1;
        if (blink_ph >= period) begin
            blink_ph = '0;
            led_q = ~led_q;
        end
    endfunction

    function automatic calib_result_t calibrator_step(input logic [SAMPLE_W-1:0] smp,
                                                      input logic btn);
        calib_result_t r;
        int            scaled;
        case (cal_mode)
            MODE_CODE_STARTUP: begin
                if (tick_cnt != TICK_MAX) tick_cnt = tick_cnt + 1'b1;
                advance_blink(cfg_start_blink);
                if (tick_cnt >= cfg_start_ticks) begin
                    led_q = 1'b1;
                    cal_mode = MODE_CODE_WORK;
                    tick_cnt = '0;
                    blink_ph = '0;
                end
            end
            MODE_CODE_WORK: begin
                win_sum = win_sum + SUM_W'(smp);
                win_cnt = win_cnt + 1'b1;
                if (win_cnt >= WINDOW_LEN) begin
                    avg_q = SAMPLE_W'(int'(win_sum) / WINDOW_LEN);
                    win_sum = '0;
                    win_cnt = '0;
                end
                flame_q = (avg_q >= thr_q);
                if (btn) begin
                    if (tick_cnt != TICK_MAX) tick_cnt = tick_cnt + 1'b1;
                end else begin
                    tick_cnt = '0;
                end
                if (tick_cnt >= cfg_hold) begin
                    cal_mode = MODE_CODE_PROGRAM;
                    tick_cnt = '0;
                    blink_ph = '0;
                end
            end
            MODE_CODE_PROGRAM: begin
                advance_blink(cfg_prog_blink);
                if (!btn) begin
                    cal_mode = MODE_CODE_CAPTURE;
                    win_cnt = '0;
                    win_sum = '0;
                end
            end
            default: begin
                win_sum = win_sum + SUM_W'(smp);
                win_cnt = win_cnt + 1'b1;
                if (win_cnt >= WINDOW_LEN) begin
                    scaled = (int'(win_sum) / WINDOW_LEN) * int'(cfg_scale) / 100;
                    thr_q = (scaled > int'(THR_MAX)) ? THR_MAX : SAMPLE_W'(scaled);
                    led_q = 1'b1;
                    cal_mode = MODE_CODE_WORK;
                    tick_cnt = '0;
                    blink_ph = '0;
                    win_cnt = '0;
                    win_sum = '0;
                end
            end
        endcase
        r.flame = flame_q;
        r.led   = led_q;
        r.mode  = cal_mode;
        r.thr   = thr_q;
        r.avg   = avg_q;
        return r;
    endfunction

    function automatic void check_field(input string fname, input int want, input int got);
        if (want != got) begin
            mismatch_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        end
    endfunction

    // Predictor, scoreboard and watchdog, all on the rising edge.
    always @(posedge i_clk) begin
        calib_result_t want;
        calib_result_t got;
        if (!i_rst_n) begin
            cfg_hold        = HOLD_TICKS_RST;
            cfg_prog_blink  = PROG_BLINK_RST;
            cfg_start_ticks = STARTUP_TICKS_RST;
            cfg_start_blink = START_BLINK_RST;
            cfg_scale       = SCALE_RST;
            cfg_preload     = THR_PRELOAD_RST;
            cal_mode = MODE_CODE_STARTUP;
            win_cnt  = '0;
            win_sum  = '0;
            avg_q    = '0;
            thr_q    = THR_PRELOAD_RST;
            tick_cnt = '0;
            blink_ph = '0;
            led_q    = 1'b1;
            flame_q  = 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HOLD_TICKS:    cfg_hold = i_cfg_data[TICK_W-1:0];
                    CFG_PROG_BLINK:    cfg_prog_blink = i_cfg_data[PHASE_W-1:0];
                    CFG_STARTUP_TICKS: cfg_start_ticks = i_cfg_data[TICK_W-1:0];
                    CFG_START_BLINK:   cfg_start_blink = i_cfg_data[PHASE_W-1:0];
                    CFG_SCALE:         cfg_scale = i_cfg_data[SCALE_W-1:0];
                    CFG_THR_PRELOAD: begin
                        cfg_preload = i_cfg_data[SAMPLE_W-1:0];
                        thr_q = cfg_preload;
                    end
                    default: ;
                endcase
            end
            idle_cycles++;
            if (s_axis_tvalid && s_axis_tready) begin
                idle_cycles = 0;
                want = calibrator_step(s_axis_tdata[SAMPLE_W-1:0], s_axis_tdata[SAMPLE_W]);
                result_q.push_back(tick_typed ? tick_typed_res : want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                idle_cycles = 0;
                got = calib_result_t'(m_axis_tdata[OUT_AVG_LSB+SAMPLE_W-1:0]);
                if (result_q.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: result beat with nothing expected, actual %h", $time, got);
                end else begin
                    want = result_q.pop_front();
                    check_field("flame_detected", want.flame, got.flame);
                    check_field("indicator_led", want.led, got.led);
                    check_field("mode_now", want.mode, got.mode);
                    check_field("threshold_level", want.thr, got.thr);
                    check_field("block_average", want.avg, got.avg);
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Receiver: stretches of steady, random, periodic and stalled ready.
    initial begin
        int kind;
        int len;
        int period;
        m_axis_tready = 1'b0;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                repeat (LONG_HOLD) begin
                    @(negedge i_clk);
                    m_axis_tready = 1'b0;
                end
            end
            kind   = $urandom_range(0, 3);
            len    = (kind == 3) ? $urandom_range(1, 8) : $urandom_range(1, 60);
            period = $urandom_range(2, 5);
            for (int k = 0; k < len; k++) begin
                if (long_hold_req) break;
                @(negedge i_clk);
                case (kind)
                    0: m_axis_tready = 1'b1;
                    1: m_axis_tready = $urandom_range(0, 1);
                    2: m_axis_tready = (k % period == 0);
                    default: m_axis_tready = 1'b0;
                endcase
            end
        end
    end

    function automatic calib_result_t calib_res(input logic flame, input logic led,
                                                input logic [1:0] mode,
                                                input logic [SAMPLE_W-1:0] thr,
                                                input logic [SAMPLE_W-1:0] avg);
        calib_result_t r;
        r.flame = flame;
        r.led   = led;
        r.mode  = mode;
        r.thr   = thr;
        r.avg   = avg;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        stim_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    function automatic stim_row_t tick_row(input logic [SAMPLE_W-1:0] smp, input logic btn,
                                           input logic [3:0] rep);
        stim_row_t r;
        r = '0;
        r.kind = ROW_TICK;
        r.smp  = smp;
        r.btn  = btn;
        r.rep  = rep;
        return r;
    endfunction

    function automatic stim_row_t tick_chk(input logic [SAMPLE_W-1:0] smp, input logic btn,
                                           input calib_result_t res);
        stim_row_t r;
        r = tick_row(smp, btn, 4'd1);
        r.typed = 1'b1;
        r.res   = res;
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int base, input int spread);
        int v;
        case ($urandom_range(0, 31))
            0: v = 0;
            1: v = int'(THR_MAX);
            2, 3, 4, 5: v = $urandom_range(0, int'(THR_MAX));
            default: v = base + $urandom_range(0, 2 * spread) - spread;
        endcase
        if (v < 0) v = 0;
        if (v > int'(THR_MAX)) v = int'(THR_MAX);
        return SAMPLE_W'(v);
    endfunction

    // Drops the offered beat and waits until every expected result is back.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic send_tick(input logic [SAMPLE_W-1:0] smp, input logic btn, input logic typed,
                             input calib_result_t res);
        int gap;
        if (burst_left == 0) begin
            gap = free_run ? 0 : $urandom_range(0, 12);
            burst_left = $urandom_range(1, 40);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid  = 1'b1;
        s_axis_tdata   = {{(IN_DATA_W-SAMPLE_W-1){1'b0}}, btn, smp};
        tick_typed     = typed;
        tick_typed_res = res;
        do @(posedge i_clk); while (!s_axis_tready);
        ticks_sent++;
    endtask

    stim_row_t dir_table [DIR_ROWS];

    initial begin
        int            phase;
        int            hold;
        int            work_base;
        int            cap_base;
        int            spread;
        int            nloop;
        int            plen;
        int            rand_start;
        calib_result_t no_res;

        no_res         = '0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        tick_typed     = 1'b0;
        tick_typed_res = '0;

        dir_table = '{
            // Startup with a zero blink period toggles on every tick.
            cfg_row(CFG_START_BLINK, 12'd0),
            cfg_row(CFG_STARTUP_TICKS, 12'd1023),
            tick_chk(12'hFFF, 1'b1, calib_res(1'b0, 1'b0, MODE_CODE_STARTUP, 12'd0, 12'd0)),
            tick_chk(12'h000, 1'b0, calib_res(1'b0, 1'b1, MODE_CODE_STARTUP, 12'd0, 12'd0)),
            cfg_row(CFG_START_BLINK, 12'd255),
            tick_row(12'h555, 1'b1, 4'd2),
            // Shortening the startup length ends startup on the next tick.
            cfg_row(CFG_STARTUP_TICKS, 12'd0),
            tick_chk(12'hAAA, 1'b0, calib_res(1'b0, 1'b1, MODE_CODE_WORK, 12'd0, 12'd0)),
            cfg_row(CFG_THR_PRELOAD, 12'hFFF),
            // Zero hold length leaves work mode at once, button released or not.
            cfg_row(CFG_HOLD_TICKS, 12'd0),
            tick_chk(12'hFFF, 1'b0, calib_res(1'b0, 1'b1, MODE_CODE_PROGRAM, 12'hFFF, 12'd0)),
            cfg_row(CFG_PROG_BLINK, 12'd0),
            tick_chk(12'h000, 1'b1, calib_res(1'b0, 1'b0, MODE_CODE_PROGRAM, 12'hFFF, 12'd0)),
            tick_chk(12'h000, 1'b0, calib_res(1'b0, 1'b1, MODE_CODE_CAPTURE, 12'hFFF, 12'd0)),
            // Full-scale capture with a scale above 100 saturates the threshold.
            cfg_row(CFG_SCALE, 12'd127),
            tick_row(12'hFFF, 1'b1, 4'd9),
            tick_chk(12'hFFF, 1'b0, calib_res(1'b0, 1'b1, MODE_CODE_WORK, 12'hFFF, 12'd0)),
            cfg_row(CFG_HOLD_TICKS, 12'd1023),
            cfg_row(CFG_SCALE, 12'd0),
            // Flame before the first block compares the reset average.
            cfg_row(CFG_THR_PRELOAD, 12'd0),
            tick_chk(12'h000, 1'b0, calib_res(1'b1, 1'b1, MODE_CODE_WORK, 12'd0, 12'd0)),
            // Writes to unused indexes must leave the threshold alone.
            cfg_row(CFG_IDX_SPARE_A, 12'hFFF),
            cfg_row(CFG_IDX_SPARE_B, 12'h5A5),
            tick_row(12'hFFF, 1'b1, 4'd9),
            tick_row(12'h000, 1'b0, 4'd1)
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_table[r]) begin
            if (dir_table[r].kind == ROW_CFG) begin
                write_cfg(dir_table[r].idx, dir_table[r].data);
            end else begin
                repeat (dir_table[r].rep)
                    send_tick(dir_table[r].smp, dir_table[r].btn, dir_table[r].typed,
                              dir_table[r].res);
            end
        end

        // Random phases: hold, program and capture cycles with random content.
        rand_start = ticks_sent;
        phase = 0;
        while (ticks_sent - rand_start < RAND_TICKS) begin
            if (phase == 2) begin
                hold = 1023;
            end else begin
                case ($urandom_range(0, 5))
                    0: hold = 0;
                    1: hold = 1;
                    2, 3: hold = $urandom_range(2, 12);
                    4: hold = $urandom_range(13, 40);
                    default: hold = $urandom_range(1, 6);
                endcase
            end
            write_cfg(CFG_HOLD_TICKS, CFG_DATA_W'(hold));
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 3))
                    0: write_cfg(CFG_PROG_BLINK, 12'd0);
                    1: write_cfg(CFG_PROG_BLINK, 12'd255);
                    default: write_cfg(CFG_PROG_BLINK, CFG_DATA_W'($urandom_range(1, 8)));
                endcase
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 5))
                    0: write_cfg(CFG_SCALE, 12'd0);
                    1: write_cfg(CFG_SCALE, 12'd100);
                    2: write_cfg(CFG_SCALE, 12'd127);
                    3: write_cfg(CFG_SCALE, 12'd95);
                    default: write_cfg(CFG_SCALE, CFG_DATA_W'($urandom_range(0, 127)));
                endcase
            end
            if ($urandom_range(0, 3) == 0)
                write_cfg(CFG_THR_PRELOAD, CFG_DATA_W'($urandom_range(0, 4095)));
            if ($urandom_range(0, 3) == 0) begin
                write_cfg(CFG_STARTUP_TICKS, CFG_DATA_W'($urandom_range(0, 1023)));
                write_cfg(CFG_START_BLINK, CFG_DATA_W'($urandom_range(0, 255)));
            end

            free_run = (phase == 1) || ($urandom_range(0, 5) == 0);
            if (phase == 1) long_hold_req = 1'b1;
            cap_base  = $urandom_range(0, 4095);
            work_base = cap_base + $urandom_range(0, 600) - 300;
            spread    = $urandom_range(0, 400);
            nloop     = ((phase == 1) || (phase == 2)) ? 1 : $urandom_range(2, 5);

            repeat (nloop) begin
                repeat ((phase == 1) ? $urandom_range(120, 160) : $urandom_range(0, 25))
                    send_tick(pick_sample(work_base, spread), $urandom_range(0, 7) == 0,
                              1'b0, no_res);
                // Mostly a full hold; now and then an early release.
                plen = hold + $urandom_range(0, 8);
                if ($urandom_range(0, 5) == 0) plen = $urandom_range(0, hold);
                repeat (plen)
                    send_tick(pick_sample(work_base, spread), 1'b1, 1'b0, no_res);
                send_tick(pick_sample(cap_base, spread), 1'b0, 1'b0, no_res);
                repeat ($urandom_range(10, 14))
                    send_tick(pick_sample(cap_base, spread), $urandom_range(0, 3) == 0,
                              1'b0, no_res);
            end
            free_run = 1'b0;
            phase++;
        end

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (mismatch_cnt == 0 && result_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
